@@ rtl/tlbpt_pkg.sv @@
// Shared types, constants and helpers for the TLB / page table translator.
// No dependencies; imported by tlbpt_tlb and tlb_page_table_translator.

package tlbpt_pkg;

  // Geometry. PAGE_COUNT is a power of two: the page number is the low
  // PAGE_W bits of the address above the offset.
  localparam int unsigned VA_W         = 16;
  localparam int unsigned TLB_ENTRIES  = 16;
  localparam int unsigned PAGE_COUNT   = 256;
  localparam int unsigned OFFSET_WIDTH = 8;
  localparam int unsigned COUNT_W      = 32;

  localparam int unsigned PAGE_W    = $clog2(PAGE_COUNT);
  localparam int unsigned TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int unsigned WIDE_W    = PAGE_W + VA_W;

  localparam logic [VA_W-1:0] OFF_MASK = VA_W'((64'd1 << OFFSET_WIDTH) - 64'd1);
  localparam logic [PAGE_W-1:0] LAST_FRAME = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [TLB_IDX_W-1:0] LAST_SLOT = TLB_IDX_W'(TLB_ENTRIES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [PAGE_W-1:0] frame_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } tlbpt_state_e;

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlbpt_lookup_t;

  typedef struct packed {
    logic   we;
    page_t  page;
    frame_t frame;
  } tlbpt_fill_t;

  function automatic page_t page_of(input logic [VA_W-1:0] va);
    logic [VA_W-1:0] sh;
    sh = va >> OFFSET_WIDTH;
    return PAGE_W'(sh);
  endfunction

  function automatic logic [VA_W-1:0] phys_of(input frame_t frame,
                                              input logic [VA_W-1:0] va);
    logic [WIDE_W-1:0] w;
    w = (WIDE_W'(frame) << OFFSET_WIDTH) | WIDE_W'(va & OFF_MASK);
    return VA_W'(w);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

@@ rtl/tlbpt_tlb.sv @@
// Fully associative TLB with FIFO replacement: parallel tag compare, one fill port.
// Depends on tlbpt_pkg.

module tlbpt_tlb import tlbpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  page_t         lookup_page_i,
  input  tlbpt_fill_t   fill_i,
  output tlbpt_lookup_t lookup_o
);

  page_t                  tags_q   [TLB_ENTRIES];
  frame_t                 frames_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_q;
  logic [TLB_IDX_W-1:0]   ptr_q;
  logic [TLB_IDX_W-1:0]   hit_idx;
  logic                   hit;

  // Lowest matching slot wins; scan from the top so lower slots override.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (tags_q[i] == lookup_page_i)) begin
        hit     = 1'b1;
        hit_idx = TLB_IDX_W'(i);
      end
    end
  end

  assign lookup_o.hit   = hit;
  assign lookup_o.frame = frames_q[hit_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else if (fill_i.we) begin
      valid_q[ptr_q] <= 1'b1;
      ptr_q          <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + TLB_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i.we) begin
      tags_q[ptr_q]   <= fill_i.page;
      frames_q[ptr_q] <= fill_i.frame;
    end
  end

endmodule

@@ rtl/tlb_page_table_translator.sv @@
// Top level: virtual-to-physical translator with TLB and demand-paged page table.
// Depends on tlbpt_pkg and tlbpt_tlb.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ---------------------------------------
//  request   in         start high, busy low   virtual_address_i
//  result    out        done_o (one cycle)     physical_address_o, tlb_hit_o,
//                                              page_fault_o, *_count_o
//
// For each address, the accept edge issues the page table read,
// and the following edge resolves hit / table / fault, writes back the page
// table and TLB, and registers the result. done_o is high in the cycle after
// that; busy is high only during the resolve cycle, so a new transfer may be
// taken while the result is shown. The receiver cannot stall. Reset clears the
// valid bits, the FIFO pointer, the free-frame counter and all counts.

module tlb_page_table_translator import tlbpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [VA_W-1:0]    virtual_address_i,
  output logic               busy,
  output logic               done_o,
  output logic [VA_W-1:0]    physical_address_o,
  output logic               tlb_hit_o,
  output logic               page_fault_o,
  output logic [COUNT_W-1:0] translated_count_o,
  output logic [COUNT_W-1:0] hit_count_o,
  output logic [COUNT_W-1:0] fault_count_o
);

  tlbpt_state_e state_q, state_d;
  logic         accept;
  logic         resolve;

  logic [VA_W-1:0]        va_q;
  page_t                  page_in;
  page_t                  page_q;
  frame_t                 pt_mem [PAGE_COUNT];
  frame_t                 pt_rdata_q;
  logic [PAGE_COUNT-1:0]  pt_valid_q;
  logic                   pt_hit;
  frame_t                 next_free_q;

  tlbpt_lookup_t lookup;
  tlbpt_fill_t   fill;
  logic          fault;
  frame_t        frame;

  logic               done_q;
  logic [VA_W-1:0]    phys_q;
  logic               hit_q;
  logic               fault_q;
  logic [COUNT_W-1:0] trans_cnt_q;
  logic [COUNT_W-1:0] hit_cnt_q;
  logic [COUNT_W-1:0] fault_cnt_q;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    resolve = 1'b0;
    unique case (state_q)
      ST_IDLE:   busy = 1'b0;
      ST_LOOKUP: begin
        busy    = 1'b1;
        resolve = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Page table memory: read on the accept edge, write back on the resolve edge.
  // A write lands before the earliest next read, so no forwarding.
  // ---------------------------------------------------------------------------
  assign page_in = page_of(virtual_address_i);
  assign page_q  = page_of(va_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q       <= virtual_address_i;
      pt_rdata_q <= pt_mem[page_in];
    end
    if (fault) begin
      pt_mem[page_q] <= next_free_q;
    end
  end

  assign pt_hit = pt_valid_q[page_q];

  // ---------------------------------------------------------------------------
  // TLB lookup and fill
  // ---------------------------------------------------------------------------
  tlbpt_tlb u_tlb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lookup_page_i (page_q),
    .fill_i        (fill),
    .lookup_o      (lookup)
  );

  // Hit uses the TLB frame; a table hit uses the read data; otherwise fault.
  always_comb begin
    fault = resolve && !lookup.hit && !pt_hit;
    priority if (lookup.hit) begin
      frame = lookup.frame;
    end else if (pt_hit) begin
      frame = pt_rdata_q;
    end else begin
      frame = next_free_q;
    end
    fill.we    = resolve && !lookup.hit;
    fill.page  = page_q;
    fill.frame = frame;
  end

  // ---------------------------------------------------------------------------
  // State update and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q  <= '0;
      next_free_q <= '0;
      trans_cnt_q <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= resolve;
      if (resolve) begin
        trans_cnt_q <= sat_inc(trans_cnt_q);
        if (lookup.hit) hit_cnt_q <= sat_inc(hit_cnt_q);
      end
      if (fault) begin
        pt_valid_q[page_q] <= 1'b1;
        next_free_q        <= (next_free_q == LAST_FRAME) ? '0 : next_free_q + PAGE_W'(1);
        fault_cnt_q        <= sat_inc(fault_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve) begin
      phys_q  <= phys_of(frame, va_q);
      hit_q   <= lookup.hit;
      fault_q <= fault;
    end
  end

  assign done_o             = done_q;
  assign physical_address_o = phys_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign translated_count_o = trans_cnt_q;
  assign hit_count_o        = hit_cnt_q;
  assign fault_count_o      = fault_cnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_follows_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a preceding resolve cycle");

  a_lookup_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("resolve cycle did not finish in one cycle");

  a_fault_not_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(tlb_hit_o && page_fault_o))
    else $error("fault reported on a TLB hit");

  a_fault_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && page_fault_o) |->
      ((fault_count_o != $past(fault_count_o)) || (fault_count_o == COUNT_MAX)))
    else $error("fault count did not advance on a fault");

endmodule

@@ sim/tlb_page_table_translator_tb.sv @@
// Self-checking bench for tlb_page_table_translator: TLB hits, table reads, page faults.
// Depends on tlbpt_pkg (geometry, page_t/frame_t) and the translator RTL.

module tlb_page_table_translator_tb;
  import tlbpt_pkg::*;

  localparam int unsigned RANDOM_ADDRS  = 1100;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned RECENT_DEPTH  = 8;
  localparam int unsigned RECENT_IDX_W  = $clog2(RECENT_DEPTH);
  localparam int unsigned DIRECTED_ROWS = 22;

  // One translation as the block reports it.
  typedef struct {
    logic [VA_W-1:0]    phys;
    logic               hit;
    logic               fault;
    logic [COUNT_W-1:0] n_xlat;
    logic [COUNT_W-1:0] n_hit;
    logic [COUNT_W-1:0] n_fault;
  } xlate_t;

  // Directed row: address plus, where obvious, the typed-in answer.
  typedef struct packed {
    logic [VA_W-1:0] va;
    logic            typed;
    logic [VA_W-1:0] phys;
    logic            hit;
    logic            fault;
  } addr_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic [VA_W-1:0]    virtual_address_i;
  logic               busy;
  logic               done_o;
  logic [VA_W-1:0]    physical_address_o;
  logic               tlb_hit_o;
  logic               page_fault_o;
  logic [COUNT_W-1:0] translated_count_o;
  logic [COUNT_W-1:0] hit_count_o;
  logic [COUNT_W-1:0] fault_count_o;

  tlb_page_table_translator uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .virtual_address_i  (virtual_address_i),
    .busy               (busy),
    .done_o             (done_o),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .translated_count_o (translated_count_o),
    .hit_count_o        (hit_count_o),
    .fault_count_o      (fault_count_o)
  );

  // Shadow copy of the translator state, advanced once per accepted address.
  page_t              tlb_tag   [TLB_ENTRIES];
  frame_t             tlb_frame [TLB_ENTRIES];
  logic               tlb_live  [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0] fifo_slot;
  frame_t             pt_frame  [PAGE_COUNT];
  logic               pt_mapped [PAGE_COUNT];
  frame_t             free_frame;
  logic [COUNT_W-1:0] xlat_total;
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] fault_total;

  xlate_t      pending_xlates [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned calm_left;
  page_t       recent_pages [RECENT_DEPTH];
  addr_row_t   directed_rows [DIRECTED_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] n);
    return (n == '1) ? n : n + COUNT_W'(1);
  endfunction

  // Translate one address against the shadow state and update that state:
  // TLB compare first (lowest live slot wins), then the page table, then a
  // fresh frame on a fault. Every miss refills the TLB at the FIFO slot.
  function automatic xlate_t translate_address(input logic [VA_W-1:0] va);
    xlate_t             r;
    page_t              page;
    frame_t             frame;
    logic [WIDE_W-1:0]  wide;
    page  = page_t'(va >> OFFSET_WIDTH);
    frame = '0;
    r.hit   = 1'b0;
    r.fault = 1'b0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_live[i] && tlb_tag[i] == page) begin
        r.hit = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (!r.hit) begin
      if (pt_mapped[page]) begin
        frame = pt_frame[page];
      end else begin
        r.fault         = 1'b1;
        frame           = free_frame;
        free_frame      = free_frame + PAGE_W'(1);
        pt_frame[page]  = frame;
        pt_mapped[page] = 1'b1;
      end
      tlb_tag[fifo_slot]   = page;
      tlb_frame[fifo_slot] = frame;
      tlb_live[fifo_slot]  = 1'b1;
      fifo_slot            = fifo_slot + TLB_IDX_W'(1);
    end
    xlat_total = bump(xlat_total);
    if (r.hit)   hit_total   = bump(hit_total);
    if (r.fault) fault_total = bump(fault_total);
    // Frame bits above the address width fall off.
    wide = WIDE_W'(frame) << OFFSET_WIDTH;
    wide[OFFSET_WIDTH-1:0] = va[OFFSET_WIDTH-1:0];
    r.phys    = wide[VA_W-1:0];
    r.n_xlat  = xlat_total;
    r.n_hit   = hit_total;
    r.n_fault = fault_total;
    return r;
  endfunction

  // Present one address after a random idle gap, hold it until the transfer
  // happens, then queue what the block must answer. A typed row overrides
  // the predicted address and flags; counts always come from the shadow.
  task automatic send_address(input logic [VA_W-1:0] va, input logic typed,
                              input logic [VA_W-1:0] t_phys, input logic t_hit,
                              input logic t_fault);
    int unsigned gap;
    xlate_t      r;
    if (calm_left != 0) begin
      gap = 0;
      calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap       = 0;
      calm_left = $urandom_range(5, 40);
    end else begin
      gap = $urandom_range(0, 19);
    end
    // Drop start only when idling; a back-to-back transfer keeps it high.
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    virtual_address_i <= va;
    do @(posedge clk_i); while (busy);
    r = translate_address(va);
    if (typed) begin
      r.phys  = t_phys;
      r.hit   = t_hit;
      r.fault = t_fault;
    end
    pending_xlates.push_back(r);
    recent_pages[RECENT_IDX_W'($urandom_range(0, RECENT_DEPTH - 1))] =
      page_t'(va >> OFFSET_WIDTH);
  endtask

  // Result checker: every strobe must match the oldest pending translation.
  always @(posedge clk_i) begin : check_result
    xlate_t want;
    if (rst_ni && done_o) begin
      if (pending_xlates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: pa=%h hit=%b fault=%b", physical_address_o,
                   tlb_hit_o, page_fault_o);
      end else begin
        want = pending_xlates.pop_front();
        if (physical_address_o !== want.phys || tlb_hit_o !== want.hit ||
            page_fault_o !== want.fault || translated_count_o !== want.n_xlat ||
            hit_count_o !== want.n_hit || fault_count_o !== want.n_fault) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch exp: pa=%h hit=%b fault=%b n=%0d hits=%0d faults=%0d",
                     want.phys, want.hit, want.fault, want.n_xlat, want.n_hit,
                     want.n_fault);
            $display("         got: pa=%h hit=%b fault=%b n=%0d hits=%0d faults=%0d",
                     physical_address_o, tlb_hit_o, page_fault_o, translated_count_o,
                     hit_count_o, fault_count_o);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    page_t           page;
    logic [VA_W-1:0] va;
    int unsigned     pick;
    page_t           sweep_page;

    start             <= 1'b0;
    virtual_address_i <= '0;
    rst_ni            <= 1'b0;
    calm_left   = 0;
    sweep_page  = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) tlb_live[i] = 1'b0;
    for (int i = 0; i < PAGE_COUNT; i++) pt_mapped[i] = 1'b0;
    for (int i = 0; i < RECENT_DEPTH; i++) recent_pages[i] = '0;
    fifo_slot   = '0;
    free_frame  = '0;
    xlat_total  = '0;
    hit_total   = '0;
    fault_total = '0;

    // Directed rows: first faults hand out frames 0, 1, 2, ... in order;
    // pages 01..0A fill the TLB, 0B evicts page 00, and the return of
    // page 00 evicts FF, so both come back through a plain table read.
    directed_rows = '{
      '{16'h0000, 1'b1, 16'h0000, 1'b0, 1'b1},
      '{16'h00FF, 1'b1, 16'h00FF, 1'b1, 1'b0},
      '{16'hFFFF, 1'b1, 16'h01FF, 1'b0, 1'b1},
      '{16'hFF00, 1'b1, 16'h0100, 1'b1, 1'b0},
      '{16'h8000, 1'b1, 16'h0200, 1'b0, 1'b1},
      '{16'h7FFF, 1'b1, 16'h03FF, 1'b0, 1'b1},
      '{16'h5555, 1'b1, 16'h0455, 1'b0, 1'b1},
      '{16'hAAAA, 1'b1, 16'h05AA, 1'b0, 1'b1},
      '{16'h0137, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h02C8, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0301, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h04FE, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0580, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h067F, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0710, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h08EF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0902, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0AFD, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0B42, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0081, 1'b1, 16'h0081, 1'b0, 1'b0},
      '{16'hFF7E, 1'b1, 16'h017E, 1'b0, 1'b0},
      '{16'h0BFF, 1'b0, 16'h0000, 1'b0, 1'b0}
    };

    // Hold reset low from the start, then release it once for good.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k])
      send_address(directed_rows[k].va, directed_rows[k].typed,
                   directed_rows[k].phys, directed_rows[k].hit,
                   directed_rows[k].fault);

    // Random part: reuse of recent pages for TLB hits, uniform pages for
    // misses, and a page sweep that maps every page and wraps the frame
    // counter. Offsets are always random.
    for (int n = 0; n < RANDOM_ADDRS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        page = recent_pages[RECENT_IDX_W'($urandom_range(0, RECENT_DEPTH - 1))];
      end else if (pick < 7) begin
        page = page_t'($urandom_range(0, PAGE_COUNT - 1));
      end else begin
        page       = sweep_page;
        sweep_page = sweep_page + PAGE_W'(1);
      end
      va = (VA_W'(page) << OFFSET_WIDTH) | (VA_W'($urandom) & OFF_MASK);
      send_address(va, 1'b0, '0, 1'b0, 1'b0);
    end
    start <= 1'b0;

    // Drain: wait for every pending result, then a few quiet cycles.
    while (pending_xlates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_xlates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tlbpt_pkg.sv
rtl/tlbpt_tlb.sv
rtl/tlb_page_table_translator.sv
sim/tlb_page_table_translator_tb.sv
